// ===== src/bor_pkg.sv =====
// shared types and constants for the box overlap ratio block
// no dependencies
`default_nettype none

package bor_pkg;

  // field widths
  localparam int COORD_W  = 16;
  localparam int SIZE_W   = 15;
  localparam int EXT_W    = 15;
  localparam int AREA_W   = 30;
  localparam int DIV_W    = 31;
  localparam int RATIO_W  = 17;
  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

  // front-to-back queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // divisor selection
  typedef enum logic {
    OVL_UNION = 1'b0,
    OVL_MIN   = 1'b1
  } bor_mode_t;

  // one classified pair waiting for division
  typedef struct packed {
    logic [AREA_W-1:0] inter;
    logic [DIV_W-1:0]  divisor;
    logic              zero;
  } bor_item_t;

  // queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } bor_qstat_t;

  // overlap extent on one axis, exclusive far edge
  function automatic logic [EXT_W-1:0] axis_overlap(
    input logic signed [COORD_W-1:0] a0,
    input logic [SIZE_W-1:0]         alen,
    input logic signed [COORD_W-1:0] b0,
    input logic [SIZE_W-1:0]         blen
  );
    logic signed [COORD_W:0]   lo;
    logic signed [COORD_W:0]   ae;
    logic signed [COORD_W:0]   be;
    logic signed [COORD_W:0]   hi;
    logic signed [COORD_W+1:0] d;
    lo = (a0 > b0) ? {a0[COORD_W-1], a0} : {b0[COORD_W-1], b0};
    ae = {a0[COORD_W-1], a0} + {2'b00, alen};
    be = {b0[COORD_W-1], b0} + {2'b00, blen};
    hi = (ae < be) ? ae : be;
    d  = {hi[COORD_W], hi} - {lo[COORD_W], lo};
    return (d > 0) ? d[EXT_W-1:0] : '0;
  endfunction

endpackage

`default_nettype wire

// ===== src/box_overlap_ratio.sv =====
// top level: overlap ratio of two boxes, mode register, front, queue, divider
// depends on bor_pkg, bor_front, bor_queue, bor_divider
//
// channel   direction  handshake              payload
// input     in         start high, busy low   first_*, second_* box fields
// config    in         mode_we                mode_wdata (divisor mode)
// result    out        done, one cycle        overlap_ratio, zero_divisor
//
// one box pair accepted per cycle while busy is low; the path runs through
// three front stages, one queue slot, FRACTION_BITS + 1 divider stages and
// one result register, the divider computing one quotient bit per stage
// busy rises only if the four-entry queue is full, which the divider drains
// at one beat per cycle; the receiver cannot stall results
// rst is synchronous and clears the mode register to union mode
`default_nettype none

module box_overlap_ratio
  import bor_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      mode_we,
  input  wire logic                      mode_wdata,
  input  wire logic signed [COORD_W-1:0] first_left,
  input  wire logic signed [COORD_W-1:0] first_top,
  input  wire logic [SIZE_W-1:0]         first_width,
  input  wire logic [SIZE_W-1:0]         first_height,
  input  wire logic signed [COORD_W-1:0] second_left,
  input  wire logic signed [COORD_W-1:0] second_top,
  input  wire logic [SIZE_W-1:0]         second_width,
  input  wire logic [SIZE_W-1:0]         second_height,
  output logic                           done,
  output logic [RATIO_W-1:0]             overlap_ratio,
  output logic                           zero_divisor
);

  localparam logic [RATIO_W-1:0] RATIO_CAP =
    (FRACTION_BITS >= RATIO_W) ? RATIO_MAX : RATIO_W'(1 << FRACTION_BITS);

  bor_mode_t  mode;
  bor_qstat_t qstat;
  bor_item_t  f_item;
  bor_item_t  q_item;
  logic       push;
  logic       q_valid;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= OVL_UNION;
    end else if (mode_we) begin
      mode <= bor_mode_t'(mode_wdata);
    end
  end

  // front end
  bor_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .first_left    (first_left),
    .first_top     (first_top),
    .first_width   (first_width),
    .first_height  (first_height),
    .second_left   (second_left),
    .second_top    (second_top),
    .second_width  (second_width),
    .second_height (second_height),
    .qstat         (qstat),
    .push          (push),
    .item          (f_item)
  );

  // queue, drained every cycle by the divider
  assign q_valid = !qstat.empty;

  bor_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (f_item),
    .pop     (q_valid),
    .rd_item (q_item),
    .qstat   (qstat)
  );

  // divider
  bor_divider #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_divider (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (q_valid),
    .in_item       (q_item),
    .done          (done),
    .overlap_ratio (overlap_ratio),
    .zero_divisor  (zero_divisor)
  );

  // zero divisor forces a zero ratio
  a_zero_ratio: assert property (@(posedge clk) disable iff (rst)
    done && zero_divisor |-> overlap_ratio == '0)
    else $error("nonzero ratio with zero divisor");

  // intersection never exceeds the divisor, so ratio stays at or below one
  a_ratio_cap: assert property (@(posedge clk) disable iff (rst)
    done |-> overlap_ratio <= RATIO_CAP)
    else $error("ratio above one");

  // no result beat right after a reset cycle
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result beat after reset");

  // front holds only against a full queue
  a_busy_full: assert property (@(posedge clk) disable iff (rst)
    busy |-> qstat.full)
    else $error("busy without full queue");

endmodule

`default_nettype wire

// ===== src/bor_front.sv =====
// front end: accepts a box pair and reduces it to intersection and divisor
// depends on bor_pkg
`default_nettype none

module bor_front
  import bor_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire bor_mode_t                 mode,
  input  wire logic signed [COORD_W-1:0] first_left,
  input  wire logic signed [COORD_W-1:0] first_top,
  input  wire logic [SIZE_W-1:0]         first_width,
  input  wire logic [SIZE_W-1:0]         first_height,
  input  wire logic signed [COORD_W-1:0] second_left,
  input  wire logic signed [COORD_W-1:0] second_top,
  input  wire logic [SIZE_W-1:0]         second_width,
  input  wire logic [SIZE_W-1:0]         second_height,
  input  wire bor_qstat_t                qstat,
  output logic                           push,
  output bor_item_t                      item
);

  logic              adv;
  logic              s1_valid;
  logic [EXT_W-1:0]  s1_ovx;
  logic [EXT_W-1:0]  s1_ovy;
  logic [AREA_W-1:0] s1_a1;
  logic [AREA_W-1:0] s1_a2;
  logic              s2_valid;
  logic [AREA_W-1:0] s2_inter;
  logic [AREA_W-1:0] s2_a1;
  logic [AREA_W-1:0] s2_a2;
  logic              s3_valid;
  bor_item_t         s3_item;
  logic [DIV_W-1:0]  div_next;

  // whole front holds while the last stage waits on a full queue
  assign busy = s3_valid & qstat.full;
  assign adv  = !busy;
  assign push = s3_valid & !qstat.full;
  assign item = s3_item;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= start;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // stage 1: axis extents and box areas
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ovx <= axis_overlap(first_left, first_width, second_left, second_width);
      s1_ovy <= axis_overlap(first_top, first_height, second_top, second_height);
      s1_a1  <= first_width * first_height;
      s1_a2  <= second_width * second_height;
    end
  end

  // stage 2: intersection area
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_inter <= s1_ovx * s1_ovy;
      s2_a1    <= s1_a1;
      s2_a2    <= s1_a2;
    end
  end

  // divisor by mode
  always_comb begin
    unique case (mode)
      OVL_MIN:   div_next = DIV_W'((s2_a1 < s2_a2) ? s2_a1 : s2_a2);
      OVL_UNION: div_next = DIV_W'(s2_a1) + DIV_W'(s2_a2) - DIV_W'(s2_inter);
      default:   div_next = '0;
    endcase
  end

  // stage 3: classified item
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_item.inter   <= s2_inter;
      s3_item.divisor <= div_next;
      s3_item.zero    <= (div_next == '0);
    end
  end

endmodule

`default_nettype wire

// ===== src/bor_queue.sv =====
// short queue between the front end and the divider
// depends on bor_pkg
`default_nettype none

module bor_queue
  import bor_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire bor_item_t wr_item,
  input  wire logic      pop,
  output bor_item_t      rd_item,
  output bor_qstat_t     qstat
);

  bor_item_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_pop;

  assign qstat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign do_pop      = pop & !qstat.empty;
  assign rd_item     = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== src/bor_divider.sv =====
// back end: pipelined restoring divider, one quotient bit per stage
// depends on bor_pkg
`default_nettype none

module bor_divider
  import bor_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire bor_item_t     in_item,
  output logic               done,
  output logic [RATIO_W-1:0] overlap_ratio,
  output logic               zero_divisor
);

  localparam int QW = FRACTION_BITS + 1;
  localparam int WW = (QW > RATIO_W) ? QW : RATIO_W;

  logic             vld  [QW];
  logic [DIV_W-1:0] rem  [QW];
  logic [DIV_W-1:0] dvs  [QW];
  logic [QW-1:0]    quo  [QW];
  logic             zro  [QW];
  logic [WW-1:0]    q_wide;
  logic             inter_ge;

  // quotient never exceeds one, so the top bit is a single compare
  assign inter_ge = (DIV_W'(in_item.inter) >= in_item.divisor);

  // first stage: integer bit of the quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= inter_ge ? DIV_W'(in_item.inter) - in_item.divisor
                       : DIV_W'(in_item.inter);
    dvs[0] <= in_item.divisor;
    quo[0] <= QW'(inter_ge);
    zro[0] <= in_item.zero;
  end

  // fraction stages: shift, compare, subtract
  for (genvar k = 1; k < QW; k++) begin : g_stage
    logic [DIV_W:0] rem2;
    logic           ge;

    assign rem2 = {rem[k-1], 1'b0};
    assign ge   = (rem2 >= {1'b0, dvs[k-1]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      rem[k] <= ge ? DIV_W'(rem2 - {1'b0, dvs[k-1]}) : rem2[DIV_W-1:0];
      dvs[k] <= dvs[k-1];
      quo[k] <= {quo[k-1][QW-2:0], ge};
      zro[k] <= zro[k-1];
    end
  end

  assign q_wide = WW'(quo[QW-1]);

  // result register with saturation and zero-divisor override
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    zero_divisor <= zro[QW-1];
    if (zro[QW-1]) begin
      overlap_ratio <= '0;
    end else if (q_wide > WW'(RATIO_MAX)) begin
      overlap_ratio <= RATIO_MAX;
    end else begin
      overlap_ratio <= q_wide[RATIO_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== tb/bor_checker.sv =====
// scoreboard for box_overlap_ratio: tracks the mode register, predicts each ratio
// from the accepted box pair and compares it with the result beat
// depends on bor_pkg
module bor_checker
  import bor_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic                      busy,
  input  wire logic                      mode_we,
  input  wire logic                      mode_wdata,
  input  wire logic signed [COORD_W-1:0] first_left,
  input  wire logic signed [COORD_W-1:0] first_top,
  input  wire logic [SIZE_W-1:0]         first_width,
  input  wire logic [SIZE_W-1:0]         first_height,
  input  wire logic signed [COORD_W-1:0] second_left,
  input  wire logic signed [COORD_W-1:0] second_top,
  input  wire logic [SIZE_W-1:0]         second_width,
  input  wire logic [SIZE_W-1:0]         second_height,
  input  wire logic                      done,
  input  wire logic [RATIO_W-1:0]        overlap_ratio,
  input  wire logic                      zero_divisor,
  output int                             errors,
  output int                             pending,
  output int                             checked,
  output int                             zero_hits
);

  localparam int REPORT_CAP = 20;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic               zero;
  } ratio_beat_t;

  bor_mode_t   mode_q;
  ratio_beat_t ratio_q[$];

  // overlap on one axis, far edge exclusive, never negative
  function automatic longint span_overlap(input longint a0, input longint alen,
                                          input longint b0, input longint blen);
    longint lo;
    longint hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  // intersection over union or over the smaller area, truncated fixed point
  function automatic ratio_beat_t predict_beat(
    input bor_mode_t                   m,
    input logic signed [COORD_W-1:0]   fl,
    input logic signed [COORD_W-1:0]   ft,
    input logic [SIZE_W-1:0]           fw,
    input logic [SIZE_W-1:0]           fh,
    input logic signed [COORD_W-1:0]   sl,
    input logic signed [COORD_W-1:0]   st,
    input logic [SIZE_W-1:0]           sw,
    input logic [SIZE_W-1:0]           sh
  );
    longint      inter;
    longint      area_a;
    longint      area_b;
    longint      divisor;
    longint      quot;
    ratio_beat_t r;
    inter  = span_overlap(longint'(fl), longint'(fw), longint'(sl), longint'(sw)) *
             span_overlap(longint'(ft), longint'(fh), longint'(st), longint'(sh));
    area_a = longint'(fw) * longint'(fh);
    area_b = longint'(sw) * longint'(sh);
    if (m == OVL_MIN) begin
      divisor = (area_a < area_b) ? area_a : area_b;
    end else begin
      divisor = area_a + area_b - inter;
    end
    r = '0;
    if (divisor == 0) begin
      r.zero = 1'b1;
    end else begin
      quot = (inter << FRACTION_BITS) / divisor;
      r.ratio = (quot > longint'(RATIO_MAX)) ? RATIO_MAX : RATIO_W'(quot);
    end
    return r;
  endfunction

  // predict on each accepted pair, compare on each result beat
  always @(posedge clk) begin : score
    ratio_beat_t want;
    int          fails;
    fails = 0;
    if (rst) begin
      mode_q <= OVL_UNION;
      ratio_q.delete();
      pending <= 0;
    end else begin
      if (mode_we) begin
        mode_q <= bor_mode_t'(mode_wdata);
      end
      if (start && !busy) begin
        ratio_q.push_back(predict_beat(mode_q, first_left, first_top, first_width,
                                       first_height, second_left, second_top,
                                       second_width, second_height));
      end
      if (done) begin
        if (ratio_q.size() == 0) begin
          if (errors < REPORT_CAP) begin
            $display("%0t unexpected result beat: ratio %0d zero_divisor %0b",
                     $time, overlap_ratio, zero_divisor);
          end
          fails++;
        end else begin
          want = ratio_q.pop_front();
          if (overlap_ratio !== want.ratio) begin
            if (errors + fails < REPORT_CAP) begin
              $display("%0t overlap_ratio mismatch: expected %0d, actual %0d",
                       $time, want.ratio, overlap_ratio);
            end
            fails++;
          end
          if (zero_divisor !== want.zero) begin
            if (errors + fails < REPORT_CAP) begin
              $display("%0t zero_divisor mismatch: expected %0b, actual %0b",
                       $time, want.zero, zero_divisor);
            end
            fails++;
          end
          checked   <= checked + 1;
          zero_hits <= zero_hits + int'(want.zero);
        end
      end
      errors  <= errors + fails;
      pending <= ratio_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// testbench top for box_overlap_ratio: clock, reset, box pair stimulus, mode
// writes, watchdog and verdict; checking is done by bor_checker
// depends on bor_pkg, bor_checker, box_overlap_ratio
module tb;
  import bor_pkg::*;

  localparam int FRACTION_BITS  = 16;
  localparam int PIPE_LATENCY   = FRACTION_BITS + 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 190;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      mode_we = 1'b0;
  logic                      mode_wdata = 1'b0;
  logic signed [COORD_W-1:0] first_left = '0;
  logic signed [COORD_W-1:0] first_top = '0;
  logic [SIZE_W-1:0]         first_width = '0;
  logic [SIZE_W-1:0]         first_height = '0;
  logic signed [COORD_W-1:0] second_left = '0;
  logic signed [COORD_W-1:0] second_top = '0;
  logic [SIZE_W-1:0]         second_width = '0;
  logic [SIZE_W-1:0]         second_height = '0;
  logic                      done;
  logic [RATIO_W-1:0]        overlap_ratio;
  logic                      zero_divisor;

  int errors;
  int pending;
  int checked;
  int zero_hits;
  int idle_pct = 0;
  int pairs_sent = 0;
  int quiet_cycles = 0;

  box_overlap_ratio #(.FRACTION_BITS(FRACTION_BITS)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mode_we(mode_we), .mode_wdata(mode_wdata),
    .first_left(first_left), .first_top(first_top),
    .first_width(first_width), .first_height(first_height),
    .second_left(second_left), .second_top(second_top),
    .second_width(second_width), .second_height(second_height),
    .done(done), .overlap_ratio(overlap_ratio), .zero_divisor(zero_divisor)
  );

  bor_checker #(.FRACTION_BITS(FRACTION_BITS)) u_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mode_we(mode_we), .mode_wdata(mode_wdata),
    .first_left(first_left), .first_top(first_top),
    .first_width(first_width), .first_height(first_height),
    .second_left(second_left), .second_top(second_top),
    .second_width(second_width), .second_height(second_height),
    .done(done), .overlap_ratio(overlap_ratio), .zero_divisor(zero_divisor),
    .errors(errors), .pending(pending), .checked(checked), .zero_hits(zero_hits)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog: cycles with neither an accepted pair nor a result beat
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", pending);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // one beat on the input side, with random sender gaps in front of it
  task automatic send_pair(
    input logic signed [COORD_W-1:0] fl, input logic signed [COORD_W-1:0] ft,
    input logic [SIZE_W-1:0] fw, input logic [SIZE_W-1:0] fh,
    input logic signed [COORD_W-1:0] sl, input logic signed [COORD_W-1:0] st,
    input logic [SIZE_W-1:0] sw, input logic [SIZE_W-1:0] sh
  );
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    first_left    <= fl;
    first_top     <= ft;
    first_width   <= fw;
    first_height  <= fh;
    second_left   <= sl;
    second_top    <= st;
    second_width  <= sw;
    second_height <= sh;
    do @(posedge clk); while (busy);
    pairs_sent++;
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_mode(input bor_mode_t m);
    drain();
    repeat (PIPE_LATENCY) @(posedge clk);
    mode_we    <= 1'b1;
    mode_wdata <= m;
    @(posedge clk);
    mode_we    <= 1'b0;
  endtask

  // corner cases, run once per divisor mode
  task automatic directed_pairs();
    send_pair(16'sd0, 16'sd0, 15'd10, 15'd10, 16'sd0, 16'sd0, 15'd10, 15'd10);
    send_pair(16'sd0, 16'sd0, 15'd10, 15'd10, 16'sd50, 16'sd50, 15'd10, 15'd10);
    // touching edges share no area
    send_pair(16'sd0, 16'sd0, 15'd10, 15'd10, 16'sd10, 16'sd0, 15'd10, 15'd10);
    send_pair(16'sd0, 16'sd0, 15'd10, 15'd10, 16'sd0, 16'sd10, 15'd10, 15'd10);
    send_pair(16'sd0, 16'sd0, 15'd100, 15'd100, 16'sd20, 16'sd30, 15'd10, 15'd10);
    send_pair(16'sd5, 16'sd7, 15'd30, 15'd20, 16'sd17, 16'sd12, 15'd25, 15'd40);
    send_pair(-16'sd50, -16'sd50, 15'd40, 15'd40, -16'sd30, -16'sd30, 15'd40, 15'd40);
    // largest boxes at the extreme corners
    send_pair(-16'sd32768, -16'sd32768, 15'h7fff, 15'h7fff,
              -16'sd32768, -16'sd32768, 15'h7fff, 15'h7fff);
    send_pair(16'sd32767, 16'sd32767, 15'h7fff, 15'h7fff,
              -16'sd32768, -16'sd32768, 15'h7fff, 15'h7fff);
    send_pair(16'sd32700, 16'sd32700, 15'd100, 15'd100,
              16'sd32750, 16'sd32650, 15'd100, 15'd100);
    // zero area boxes
    send_pair(16'sd0, 16'sd0, 15'd0, 15'd10, 16'sd0, 16'sd0, 15'd10, 15'd0);
    send_pair(16'sd0, 16'sd0, 15'd20, 15'd20, 16'sd5, 16'sd5, 15'd0, 15'd5);
    // tiny box in a huge one, heavy truncation
    send_pair(-16'sd32768, -16'sd32768, 15'h7fff, 15'h7fff,
              16'sd0 - 16'sd3, 16'sd0 - 16'sd3, 15'd1, 15'd1);
  endtask

  // mostly detection-like pairs near each other, some fully random noise
  task automatic random_pair();
    int                        pick;
    int                        off;
    logic signed [COORD_W-1:0] fl, ft, sl, st;
    logic [SIZE_W-1:0]         fw, fh, sw, sh;
    pick = $urandom_range(99);
    fl = COORD_W'($urandom); ft = COORD_W'($urandom);
    sl = COORD_W'($urandom); st = COORD_W'($urandom);
    fw = SIZE_W'($urandom); fh = SIZE_W'($urandom);
    sw = SIZE_W'($urandom); sh = SIZE_W'($urandom);
    if (pick >= 15) begin
      if ($urandom_range(9) != 0) begin
        fw = SIZE_W'($urandom_range(1, 400)); fh = SIZE_W'($urandom_range(1, 400));
        sw = SIZE_W'($urandom_range(1, 400)); sh = SIZE_W'($urandom_range(1, 400));
      end
      if (pick < 30) begin
        sl = fl; st = ft; sw = fw; sh = fh;
      end else if (pick < 40) begin
        sw = SIZE_W'($urandom_range(0, fw));
        sh = SIZE_W'($urandom_range(0, fh));
        sl = COORD_W'(fl + $urandom_range(0, fw - sw));
        st = COORD_W'(ft + $urandom_range(0, fh - sh));
      end else begin
        off = $urandom_range(0, fw + sw + 8);
        sl  = COORD_W'(fl + off - sw - 4);
        off = $urandom_range(0, fh + sh + 8);
        st  = COORD_W'(ft + off - sh - 4);
      end
      if (pick >= 92) begin
        case ($urandom_range(4))
          0: fw = '0;
          1: fh = '0;
          2: sw = '0;
          3: sh = '0;
          default: begin
            fw = '0;
            sh = '0;
          end
        endcase
      end
    end
    send_pair(fl, ft, fw, fh, sl, st, sw, sh);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset leaves the block dividing by the union area
    directed_pairs();
    write_mode(OVL_MIN);
    directed_pairs();

    // random phases with sender idle chance 0%, 72%, 0%, 24%
    for (int ph = 0; ph < 4; ph++) begin
      write_mode((ph % 2 == 0) ? OVL_UNION : OVL_MIN);
      idle_pct = (ph == 1) ? 72 : (ph == 3) ? 24 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 0 && i == PHASE_ITEMS / 2) begin
          drain();
        end
        random_pair();
      end
    end

    drain();
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    $display("sent %0d box pairs in union and smaller-area modes with sender gaps",
             pairs_sent);
    $display("checked %0d result beats, %0d of them with a zero divisor",
             checked, zero_hits);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
